// File: src/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg - shared definitions for the stream pattern replace unit
// Types, constants and helpers used by the front end, queue and back end.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 8;   // default pattern depth
  localparam int unsigned HELD_MAX        = 8;   // byte slots carried in a command
  localparam int unsigned CNT_W           = 4;   // match / length counter width
  localparam int unsigned FIFO_DEPTH      = 2;
  localparam int unsigned FIFO_PTR_W      = 1;
  localparam int unsigned FIFO_CNT_W      = 2;

  localparam logic [7:0] UPPER_A     = 8'd65;
  localparam logic [7:0] UPPER_Z     = 8'd90;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [3:0] REPL_MAX    = 4'd8;

  // configuration register indexes
  localparam logic [3:0] REG_PATTERN_TEXT       = 4'd0;
  localparam logic [3:0] REG_PATTERN_LENGTH     = 4'd1;
  localparam logic [3:0] REG_REPLACEMENT_TEXT   = 4'd2;
  localparam logic [3:0] REG_REPLACEMENT_LENGTH = 4'd3;

  typedef struct packed {
    logic [63:0] pattern_text;
    logic [3:0]  pattern_length;
    logic [63:0] replacement_text;
    logic [3:0]  replacement_length;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_EMIT,     // held bytes, then the mismatching byte
    CMD_FLUSH,    // held bytes, then the end marker
    CMD_REPLACE   // replacement bytes
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [CNT_W-1:0]     count;
    logic [HELD_MAX*8-1:0] held;
    logic [7:0]           text_byte;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HELD,
    BK_TAIL,
    BK_REPL
  } back_state_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UPPER_A && b <= UPPER_Z) r = b + CASE_OFFSET;
    return r;
  endfunction

  function automatic logic [3:0] repl_len_eff(input logic [3:0] n);
    logic [3:0] r;
    r = n;
    if (n > REPL_MAX) r = REPL_MAX;
    return r;
  endfunction

endpackage

// File: src/spr_front.sv
// ----------------------------------------------------------------------------
// spr_front - request intake and match tracking
// Compares each text byte with the pattern, keeps the partial match and
// posts output commands to the queue.
// ----------------------------------------------------------------------------
module spr_front
  import spr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_text_byte,
  input  logic       fifo_full,
  output logic       push,
  output cmd_t       push_cmd
);

  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0]           held_r [MAX_PATTERN];
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [CNT_W-1:0]     count_inc;
  logic [CNT_W-1:0]     plen;
  logic [HELD_MAX*8-1:0] held_flat;
  logic [7:0]           pat_byte;
  logic                 hit;
  logic                 accept;
  logic                 held_we;

  assign in_ready  = !fifo_full;
  assign accept    = in_valid && in_ready;
  assign count_inc = count_r + CNT_W'(1);
  assign pat_byte  = cfg.pattern_text[{count_r[2:0], 3'b000} +: 8];
  assign hit       = (fold_lower(in_text_byte) == pat_byte);

  // pack held bytes, slots beyond the pattern depth read as zero
  for (genvar g = 0; g < HELD_MAX; g++) begin : g_pack
    if (g < MAX_PATTERN) begin : g_used
      assign held_flat[g*8 +: 8] = held_r[g];
    end else begin : g_pad
      assign held_flat[g*8 +: 8] = 8'h00;
    end
  end

  always_comb begin
    plen = cfg.pattern_length;
    if (plen == '0) plen = CNT_W'(1);
    if (plen > CNT_W'(MAX_PATTERN)) plen = CNT_W'(MAX_PATTERN);
  end

  always_comb begin
    count_nxt          = count_r;
    push               = 1'b0;
    held_we            = 1'b0;
    push_cmd.op        = CMD_EMIT;
    push_cmd.count     = count_r;
    push_cmd.held      = held_flat;
    push_cmd.text_byte = in_text_byte;
    if (accept) begin
      if (in_action) begin
        push_cmd.op = CMD_FLUSH;
        push        = 1'b1;
        count_nxt   = '0;
      end else if (hit) begin
        held_we = 1'b1;
        if (count_inc >= plen) begin
          push_cmd.op = CMD_REPLACE;
          push        = (repl_len_eff(cfg.replacement_length) != 4'd0);
          count_nxt   = '0;
        end else begin
          count_nxt = count_inc;
        end
      end else begin
        push      = 1'b1;
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (held_we) begin
      held_r[count_r[IDX_W-1:0]] <= in_text_byte;
    end
  end

endmodule

// File: src/spr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// spr_cmd_fifo - command queue between front and back end
// Small register FIFO; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module spr_cmd_fifo
  import spr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] fill_r;
  logic                  do_push;
  logic                  do_pop;

  assign full     = (fill_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      if (do_push && !do_pop)      fill_r <= fill_r + FIFO_CNT_W'(1);
      else if (do_pop && !do_push) fill_r <= fill_r - FIFO_CNT_W'(1);
    end
  end

endmodule

// File: src/spr_back.sv
// ----------------------------------------------------------------------------
// spr_back - result serialiser
// Takes one command at a time and plays it out byte by byte through the
// output register.
// ----------------------------------------------------------------------------
module spr_back
  import spr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       fifo_empty,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_end,
  output logic       out_last
);

  back_state_t      state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] idx_inc;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_is_end_r, out_is_end_nxt;
  logic             out_last_r, out_last_nxt;
  logic             slot_free;
  logic [7:0]       held_sel;
  logic [7:0]       repl_sel;
  logic [3:0]       rlen;

  assign idx_inc   = idx_r + CNT_W'(1);
  assign slot_free = !out_valid_r || out_ready;
  assign held_sel  = cmd_r.held[{idx_r[2:0], 3'b000} +: 8];
  assign repl_sel  = cfg.replacement_text[{idx_r[2:0], 3'b000} +: 8];
  assign rlen      = repl_len_eff(cfg.replacement_length);

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_is_end = out_is_end_r;
  assign out_last   = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    pop            = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_byte_nxt   = out_byte_r;
    out_is_end_nxt = out_is_end_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      BK_IDLE: begin
        if (!fifo_empty) begin
          pop     = 1'b1;
          cmd_nxt = head_cmd;
          idx_nxt = '0;
          if (head_cmd.op == CMD_REPLACE)  state_nxt = BK_REPL;
          else if (head_cmd.count != '0)   state_nxt = BK_HELD;
          else                             state_nxt = BK_TAIL;
        end
      end
      BK_HELD: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = held_sel;
          out_is_end_nxt = 1'b0;
          out_last_nxt   = 1'b0;
          idx_nxt        = idx_inc;
          if (idx_inc == cmd_r.count) state_nxt = BK_TAIL;
        end
      end
      BK_TAIL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (cmd_r.op == CMD_FLUSH) begin
            out_byte_nxt   = 8'h00;
            out_is_end_nxt = 1'b1;
          end else begin
            out_byte_nxt   = cmd_r.text_byte;
            out_is_end_nxt = 1'b0;
          end
          state_nxt = BK_IDLE;
        end
      end
      BK_REPL: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = repl_sel;
          out_is_end_nxt = 1'b0;
          out_last_nxt   = (idx_inc == CNT_W'(rlen));
          idx_nxt        = idx_inc;
          if (idx_inc == CNT_W'(rlen)) state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    out_byte_r   <= out_byte_nxt;
    out_is_end_r <= out_is_end_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// File: src/stream_pattern_replace_unit.sv
// ----------------------------------------------------------------------------
// stream_pattern_replace_unit - one find-and-replace pass over a byte stream
// Case-folded pattern match with replacement, flush and chainable end marker.
// ----------------------------------------------------------------------------
// A request is either a text byte or an end-of-text flush. Text bytes are
// folded to lower case (A-Z only) and matched against the pattern; matching
// bytes are held, a mismatch releases the held bytes plus the current byte,
// and a full match releases the replacement instead. A flush releases the
// held bytes followed by an end marker (is_end set, byte zero), so units can
// be chained for multi-pass substitution. out_last marks the final result of
// each request. Timing: the front end takes a request every cycle while its
// two-entry command queue has room. The back end fetches one queued command
// at a time and plays it out byte by byte through the single byte-wide
// output register, finishing it before it fetches the next. The held-byte
// store is not cleared by reset; its entries are only ever read after being
// written. Configuration is held in registers and must only change while
// the unit is idle. cfg_ready is always high; writes to indexes beyond 3
// are dropped.
// ----------------------------------------------------------------------------
module stream_pattern_replace_unit
  import spr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_text_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_end,
  output logic        out_last
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head_cmd;
  logic fifo_full;
  logic fifo_empty;

  assign cfg_ready = 1'b1;

  // register file: only the low nibble of length writes is kept
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_TEXT:       cfg_nxt.pattern_text       = cfg_data;
        REG_PATTERN_LENGTH:     cfg_nxt.pattern_length     = cfg_data[3:0];
        REG_REPLACEMENT_TEXT:   cfg_nxt.replacement_text   = cfg_data;
        REG_REPLACEMENT_LENGTH: cfg_nxt.replacement_length = cfg_data[3:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_text       <= '0;
      cfg_r.pattern_length     <= 4'd1;
      cfg_r.replacement_text   <= '0;
      cfg_r.replacement_length <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: matching and command generation
  spr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_text_byte (in_text_byte),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // decouples matching from output stalls
  spr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  // back end: serialises each command onto the byte channel
  spr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (fifo_empty),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_is_end (out_is_end),
    .out_last   (out_last)
  );

endmodule

// File: src/spr_checker.sv
// ----------------------------------------------------------------------------
// spr_checker - port-level checks for the stream pattern replace unit
// Bound to the top level; watches the result channel only.
// ----------------------------------------------------------------------------
module spr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_is_end,
  input logic       out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // the end marker always closes its request
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_last)
    else $error("end marker without last");

  // the end marker carries a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_byte == 8'h00)
    else $error("end marker with non-zero byte");

  // reset empties the output register
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stream_pattern_replace_unit spr_checker u_spr_checker (.*);

// File: tb/stream_pattern_replace_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_pattern_replace_unit_test - self-checking bench for the replace unit
// Drives text and flush requests, predicts every released byte and compares.
// ----------------------------------------------------------------------------
// Requests come from a queue that the sequencer fills. A clocked driver offers
// them, a clocked receiver raises out_ready, and a monitor predicts the result
// bytes of each accepted request and compares each accepted result with the
// oldest prediction. Settings change only once the unit has gone quiet.
// ----------------------------------------------------------------------------
module stream_pattern_replace_unit_test;
  import spr_pkg::*;

  // request kinds on in_action
  localparam logic ACT_TEXT  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // indexes with no register behind them, the unit drops these writes
  localparam logic [3:0] REG_SPARE_FIRST = 4'd4;
  localparam logic [3:0] REG_SPARE_LAST  = 4'd15;

  localparam int unsigned MAX_PAT         = 8;    // pattern depth of the unit
  localparam int unsigned MAX_BURST       = 8;    // most results of one request
  localparam int unsigned DRAIN_CYCLES    = 20;   // back end worst case plus margin
  localparam int unsigned STALL_LIMIT     = 3000; // cycles with no handshake at all
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned ITEMS_PER_HALF  = 24;

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } text_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic       last;
  } out_word_t;

  // ---------------------------------------------------------------------------
  // DUT ports, the driven inputs all known from time zero
  // ---------------------------------------------------------------------------
  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index    = '0;
  logic [63:0] cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        in_action    = ACT_TEXT;
  logic [7:0]  in_text_byte = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  out_byte;
  logic        out_is_end;
  logic        out_last;

  // ---------------------------------------------------------------------------
  // Bench state: own copy of the registers and the partial match
  // ---------------------------------------------------------------------------
  logic [63:0] pat_text_m   = '0;
  logic [3:0]  pat_len_m    = 4'd1;
  logic [63:0] repl_text_m  = '0;
  logic [3:0]  repl_len_m   = '0;
  logic [7:0]  held_m [MAX_PAT];
  int unsigned held_cnt     = 0;

  text_req_t   text_requests [$];   // requests not yet offered
  out_word_t   out_bytes_due [$];   // predicted bytes, oldest first
  text_req_t   offer;

  int          errors         = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  stream_pattern_replace_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_text_byte (in_text_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_is_end   (out_is_end),
    .out_last     (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] lower_case(input logic [7:0] b);
    if (b >= UPPER_A && b <= UPPER_Z) return b + CASE_OFFSET;
    return b;
  endfunction

  // pattern bytes actually compared: 0 behaves as 1, anything past the depth
  // is clamped to the depth
  function automatic int unsigned pattern_span();
    if (pat_len_m == 4'd0) return 1;
    if (pat_len_m > MAX_PAT) return MAX_PAT;
    return int'(pat_len_m);
  endfunction

  // Works out the bytes released by one accepted request and queues them.
  task automatic substitute_step(input logic act, input logic [7:0] b);
    out_word_t   burst [MAX_BURST];
    int unsigned n;
    int unsigned k;
    int unsigned plen;
    int unsigned rlen;
    n    = 0;
    plen = pattern_span();
    if (held_cnt >= MAX_PAT) held_cnt = 0;
    if (act == ACT_FLUSH) begin
      // held bytes first, then the end marker
      for (k = 0; k < held_cnt && n < MAX_BURST - 1; k++) begin
        burst[n] = '{held_m[k], 1'b0, 1'b0};
        n++;
      end
      held_cnt = 0;
      burst[n] = '{8'h00, 1'b1, 1'b0};
      n++;
    end else begin
      if (lower_case(b) == pat_text_m[held_cnt*8 +: 8]) begin
        held_m[held_cnt] = b;   // keep the byte as it came, not folded
        held_cnt++;
      end else begin
        // mismatch: release what was held plus this byte, restart at zero;
        // the byte itself is not tried against the first pattern byte
        for (k = 0; k < held_cnt && n < MAX_BURST - 1; k++) begin
          burst[n] = '{held_m[k], 1'b0, 1'b0};
          n++;
        end
        held_cnt = 0;
        burst[n] = '{b, 1'b0, 1'b0};
        n++;
      end
      // a shrunk length can leave the count past the end: still a full match
      if (held_cnt >= plen) begin
        rlen = (repl_len_m > MAX_BURST) ? MAX_BURST : int'(repl_len_m);
        for (k = 0; k < rlen && n < MAX_BURST; k++) begin
          burst[n] = '{repl_text_m[k*8 +: 8], 1'b0, 1'b0};
          n++;
        end
        held_cnt = 0;
      end
    end
    if (n > 0) burst[n-1].last = 1'b1;
    for (k = 0; k < n; k++) out_bytes_due.push_back(burst[k]);
  endtask

  task automatic check_out(input logic [7:0] d, input logic e, input logic l);
    out_word_t want;
    if (out_bytes_due.size() == 0) begin
      errors++;
      $display("%0t: result with nothing due: byte %h end %b last %b", $time, d, e, l);
    end else begin
      want = out_bytes_due.pop_front();
      if (d !== want.data) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, want.data, d);
      end
      if (e !== want.is_end) begin
        errors++;
        $display("%0t: out_is_end expected %b actual %b", $time, want.is_end, e);
      end
      if (l !== want.last) begin
        errors++;
        $display("%0t: out_last expected %b actual %b", $time, want.last, l);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next request, holds it steady until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (text_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offer = text_requests.pop_front();
        in_valid     <= 1'b1;
        in_action    <= offer.action;
        in_text_byte <= offer.text_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off counted down here
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on request handshake, compare on result handshake.
  // A result can never belong to a request taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) substitute_step(in_action, in_text_byte);
      if (out_valid && out_ready) check_out(out_byte, out_is_end, out_last);
    end
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d bytes still due",
               $time, STALL_LIMIT, out_bytes_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic act, input logic [7:0] b);
    text_requests.push_back('{act, b});
  endtask

  // call at a rising edge; leaves cfg_valid high for a following write
  task automatic put_reg(input logic [3:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_TEXT:       pat_text_m  = data;
      REG_PATTERN_LENGTH:     pat_len_m   = data[3:0];
      REG_REPLACEMENT_TEXT:   repl_text_m = data;
      REG_REPLACEMENT_LENGTH: repl_len_m  = data[3:0];
      default: ;              // dropped by the unit as well
    endcase
  endtask

  // full register load; length writes carry noise above bit 3
  task automatic load_setting(input logic [63:0] pt, input logic [3:0] pl,
                              input logic [63:0] rt, input logic [3:0] rl,
                              input logic spare);
    @(posedge clk);
    put_reg(REG_PATTERN_TEXT, pt);
    put_reg(REG_PATTERN_LENGTH,
            {$urandom(), 28'($urandom_range(0, 28'hFFF_FFFF)), pl});
    put_reg(REG_REPLACEMENT_TEXT, rt);
    put_reg(REG_REPLACEMENT_LENGTH,
            {$urandom(), 28'($urandom_range(0, 28'hFFF_FFFF)), rl});
    if (spare)
      put_reg(4'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
              {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // sender pause: everything taken and every byte back, then the back end's
  // latency, since a held byte or an empty replacement leaves nothing to wait on
  task automatic wait_quiet();
    while (text_requests.size() != 0 || in_valid || out_bytes_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed runs of the pattern in random case, some broken off by
  // a stray byte, with plain noise and flushes mixed in.
  task automatic queue_text(input int unsigned count);
    int unsigned made;
    int unsigned m;
    int unsigned k;
    int unsigned r;
    logic [7:0]  p;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 70) begin
        m = (r < 45) ? pattern_span() : $urandom_range(0, pattern_span() - 1);
        for (k = 0; k < m; k++) begin
          p = pat_text_m[k*8 +: 8];
          if (p >= "a" && p <= "z" && $urandom_range(1) == 1) p = p - CASE_OFFSET;
          push_req(ACT_TEXT, p);
          made++;
        end
        if (r >= 45) begin
          push_req(ACT_TEXT, 8'($urandom_range(255)));
          made++;
        end
      end else if (r < 92) begin
        p = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range("a", "e"));
        if (p >= "a" && p <= "e" && $urandom_range(1) == 1) p = p - CASE_OFFSET;
        push_req(ACT_TEXT, p);
        made++;
      end else begin
        push_req(ACT_FLUSH, 8'($urandom_range(255)));   // byte is don't-care
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] pt;
    logic [63:0] rt;
    logic [3:0]  pl;
    logic [3:0]  rl;
    int          ph;
    int          set;
    int          k;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: pattern is a single zero byte, replacement empty, so a
    // zero byte vanishes, anything else passes, and flush gives a bare marker
    push_req(ACT_TEXT, 8'h00);
    push_req(ACT_TEXT, 8'hFF);
    push_req(ACT_FLUSH, 8'h00);
    wait_quiet();

    // deepest pattern via an over-range length code, over-range replacement
    // length, and a write to a dead index
    pt = "hgfedcba";
    load_setting(pt, 4'd15, {$urandom(), $urandom()}, 4'd12, 1'b0);
    @(posedge clk);
    put_reg(REG_SPARE_LAST, {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
    @(negedge clk);
    for (k = 0; k < 8; k++)
      push_req(ACT_TEXT, (k < 4) ? pt[k*8 +: 8] - CASE_OFFSET : pt[k*8 +: 8]);
    for (k = 0; k < 7; k++) push_req(ACT_TEXT, pt[k*8 +: 8]);
    wait_quiet();

    // seven bytes held; shorten the pattern under them, the next match
    // completes at once
    @(posedge clk);
    put_reg(REG_PATTERN_LENGTH, 64'd3);
    cfg_valid <= 1'b0;
    @(negedge clk);
    push_req(ACT_TEXT, "H");
    push_req(ACT_TEXT, "a");
    push_req(ACT_TEXT, "b");
    push_req(ACT_TEXT, 8'h80);
    push_req(ACT_TEXT, "A");
    push_req(ACT_FLUSH, 8'hFF);
    wait_quiet();

    // random part: four idling regimes, two settings each, a pause mid-way
    for (ph = 0; ph < 4; ph++) begin
      for (set = 0; set < 2; set++) begin
        for (k = 0; k < 8; k++)
          pt[k*8 +: 8] = ($urandom_range(99) < 80) ? 8'($urandom_range("a", "d"))
                                                   : 8'($urandom_range(255));
        rt = {$urandom(), $urandom()};
        case ($urandom_range(9))
          0:       pl = 4'd0;
          1:       pl = 4'd8;
          2:       pl = 4'($urandom_range(9, 15));
          default: pl = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(9))
          0:       rl = 4'd0;
          1:       rl = 4'd8;
          2:       rl = 4'($urandom_range(9, 15));
          default: rl = 4'($urandom_range(1, 7));
        endcase
        // make sure the corners come up whatever the seed
        case (ph * 2 + set)
          0: begin pl = 4'd8; rl = 4'd8;  end
          2: begin pl = 4'd0; rl = 4'd0;  end
          4: begin pl = 4'd1; rl = 4'd15; end
          default: ;
        endcase
        load_setting(pt, pl, rt, rl, set == 1);

        case (ph)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
          default: begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase

        queue_text(ITEMS_PER_HALF);
        // receiver goes away while requests keep coming: queue fills, input stalls
        if (ph == 2 && set == 0) hold_left = HOLD_OFF_CYCLES;
        wait_quiet();
        queue_text(ITEMS_PER_HALF);
        wait_quiet();
      end
    end

    if (errors == 0 && out_bytes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: stream_pattern_replace_unit.f
src/spr_pkg.sv
src/spr_front.sv
src/spr_cmd_fifo.sv
src/spr_back.sv
src/stream_pattern_replace_unit.sv
src/spr_checker.sv
tb/stream_pattern_replace_unit_test.sv
